// ===== src/hll_cardinality_estimator_assert.svh =====
// Assertion macros for the port checker of the estimator.
`ifndef HLL_CARDINALITY_ESTIMATOR_ASSERT_SVH
`define HLL_CARDINALITY_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define HLL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hll assertion failed");

// Next-cycle implication, disabled in reset.
`define HLL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hll assertion failed");

`endif

// ===== src/hll_pkg.sv =====
// Package: payload types, engine interface and constants of the estimator.
`default_nettype none
package hll_pkg;

   localparam longint unsigned REG_COUNT = 64'd16384;
   localparam int unsigned SUM_FRAC = 49;

   localparam longint unsigned ALPHA_Q32 =
      (REG_COUNT == 64'd16) ? ((64'd673 << 32) / 64'd1000) :
      (REG_COUNT == 64'd32) ? ((64'd697 << 32) / 64'd1000) :
      (REG_COUNT == 64'd64) ? ((64'd709 << 32) / 64'd1000) :
      (((64'd7213 * REG_COUNT) << 32) / (64'd10000 * REG_COUNT + 64'd10790));

   localparam logic [63:0] AM2 = 64'(ALPHA_Q32 * REG_COUNT * REG_COUNT);
   localparam logic [63:0] LC_LIMIT = 64'((64'd5 * REG_COUNT) << 23);
   localparam logic [63:0] BC_LIMIT = 64'(64'd72000 << 24);
   localparam logic BC_ON = (REG_COUNT == 64'd16384);
   localparam logic [63:0] BIAS_C0 = 64'((64'd833216 << 34) / 64'd10000);
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam logic [62:0] EST_MAX = '1;
   localparam logic [14:0] ZERO_MAX = '1;

   // log2 in Q30 by repeated squaring, evaluated at elaboration only
   function automatic logic [63:0] log2_q30(input logic [63:0] n);
      logic [63:0] y;
      logic [63:0] frac;
      int k;
      int i;
      k = 0;
      frac = '0;
      for (i = 0; i < 30; i++) begin
         if ((n >> (k + 1)) != 64'd0) begin
            k = k + 1;
         end
      end
      y = n << (31 - k);
      for (i = 0; i < 30; i++) begin
         y = (y * y) >> 31;
         frac = {frac[62:0], 1'b0};
         if (y >= (64'd2 << 31)) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(k) << 30) | frac;
   endfunction

   localparam logic [63:0] LOG2_M = log2_q30(REG_COUNT);

   typedef enum logic [1:0] {
      METHOD_RAW    = 2'd0,
      METHOD_LINEAR = 2'd1,
      METHOD_BIAS   = 2'd2
   } method_type;

   typedef struct packed {
      logic [7:0] reg_value;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [62:0] estimate;
      logic [14:0] zero_count;
      logic [1:0]  method;
      logic        saturated;
   } rsp_type;

   // floor(a*b/d) request to the shared engine
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] d;
   } md_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] q;
   } md_rsp_type;

endpackage
`default_nettype wire

// ===== src/hll_muldiv.sv =====
// Shared multiply-divide engine: shift-add product, then restoring division.
`default_nettype none
module hll_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hll_pkg::md_req_type md_req,
   output hll_pkg::md_rsp_type      md_rsp
);

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] n_ff, n_in;
   logic [63:0]  r_ff, r_in;
   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [63:0]  d_ff, d_in;
   logic         done_ff, done_in;
   logic [63:0]  r_shift;
   logic         take;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      r_in = r_ff;
      a_in = a_ff;
      b_in = b_ff;
      d_in = d_ff;
      done_in = 1'b0;
      r_shift = {r_ff[62:0], n_ff[127]};
      take = r_ff[63] || (r_shift >= d_ff);
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               a_in = md_req.a;
               b_in = md_req.b;
               d_in = md_req.d;
               n_in = '0;
               cnt_in = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            // accumulate one multiplier bit, MSB first
            n_in = {n_ff[126:0], 1'b0} + (a_ff[63] ? {64'd0, b_ff} : 128'd0);
            a_in = {a_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in = '0;
               r_in = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            // one quotient bit per cycle, shifted into the dividend register
            r_in = take ? (r_shift - d_ff) : r_shift;
            n_in = {n_ff[126:0], take};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               done_in = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
      d_ff <= d_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.q = n_ff;

endmodule
`default_nettype wire

// ===== src/hll_cardinality_estimator.sv =====
// Top level: HyperLogLog register accumulation and estimate sequencer.
// Non-final requests are taken one per cycle, back to back.
// Final request: each shared multiply-divide op takes 64 multiply steps and 128
// divide steps; the raw path runs 1 op, the bias path 10 ops and linear counting
// up to 33 ops (30 squarings in the log); an empty sum skips the engine and goes
// from ST_RAW straight to ST_ROUND.
// Synchronous reset clears the sum, the zero count, the sequencer and rsp_valid.
`default_nettype none
module hll_cardinality_estimator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hll_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hll_pkg::rsp_type      rsp_data
);

   typedef enum logic [16:0] {
      ST_IDLE  = 17'h00001,
      ST_RAW   = 17'h00002,
      ST_CHECK = 17'h00004,
      ST_LOG   = 17'h00008,
      ST_LZ    = 17'h00010,
      ST_LN    = 17'h00020,
      ST_LC    = 17'h00040,
      ST_V     = 17'h00080,
      ST_V2    = 17'h00100,
      ST_V3    = 17'h00200,
      ST_V4    = 17'h00400,
      ST_P1    = 17'h00800,
      ST_P2    = 17'h01000,
      ST_N1    = 17'h02000,
      ST_N2    = 17'h04000,
      ST_DELTA = 17'h08000,
      ST_ROUND = 17'h10000
   } state_type;

   // saturate a 128-bit engine result to 64 bits
   function automatic logic [63:0] sat64(input logic [127:0] q);
      return (q[127:64] != 64'd0) ? '1 : q[63:0];
   endfunction

   state_type           state_ff, state_in;
   logic                issued_ff, issued_in;
   logic [63:0]         sum_ff, sum_in;
   logic [14:0]         zero_ff, zero_in;
   logic [127:0]        q_ff, q_in;
   logic                inf_ff, inf_in;
   hll_pkg::method_type method_ff, method_in;
   logic [63:0]         y_ff, y_in;       // log mantissa, Q31
   logic [29:0]         frac_ff, frac_in; // log fraction bits
   logic [4:0]          cnt_ff, cnt_in;   // squaring step
   logic [4:0]          k_ff, k_in;       // log integer part
   logic [63:0]         tmp_ff, tmp_in;
   logic [63:0]         e_ff, e_in;
   logic [63:0]         v_ff, v_in;
   logic [63:0]         v2_ff, v2_in;
   logic [63:0]         v3_ff, v3_in;
   logic [63:0]         v4_ff, v4_in;
   logic [63:0]         pos_ff, pos_in;
   logic [63:0]         neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   hll_pkg::rsp_type    rsp_ff, rsp_in;

   hll_pkg::md_req_type md_req;
   hll_pkg::md_rsp_type md_rsp;

   logic         accept;
   logic         out_free;
   logic         arith;
   logic [63:0]  term;
   logic [64:0]  sum_wide;
   logic [63:0]  res;
   logic [63:0]  ysq;
   logic         ybit;
   logic [4:0]   msb;
   logic [63:0]  lz;
   logic         pos_ge;
   logic [63:0]  diff;
   logic [127:0] rounded;

   hll_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign res = sat64(md_rsp.q);
   assign pos_ge = (pos_ff >= neg_ff);
   assign diff = pos_ge ? (pos_ff - neg_ff) : (neg_ff - pos_ff);
   assign lz = {29'd0, k_ff, frac_ff};
   assign rounded = q_ff + 128'h800000;

   // squaring step of the log: renormalize when the square reaches 2.0
   assign ysq = res;
   assign ybit = (ysq[63:32] != 32'd0);

   // leading one of the zero count
   always_comb begin
      msb = '0;
      for (int i = 0; i < 15; i++) begin
         if (zero_ff[i]) begin
            msb = 5'(i);
         end
      end
   end

   // weight of one register: 2^-r in 15.49, dropped below 2^-49
   always_comb begin
      term = '0;
      if (req_data.reg_value <= 8'(hll_pkg::SUM_FRAC)) begin
         term = 64'd1 << (6'(hll_pkg::SUM_FRAC) - req_data.reg_value[5:0]);
      end
      sum_wide = {1'b0, sum_ff} + {1'b0, term};
   end

   // states that run an op on the shared engine
   always_comb begin
      arith = (state_ff inside {ST_LOG, ST_LN, ST_LC, ST_V, ST_V2, ST_V3, ST_V4,
                                ST_P1, ST_P2, ST_N1, ST_N2, ST_DELTA}) ||
              ((state_ff == ST_RAW) && (sum_ff != 64'd0));
   end

   // operand select for the shared engine
   always_comb begin
      md_req.start = arith && !issued_ff;
      md_req.a = '0;
      md_req.b = '0;
      md_req.d = 64'd1;
      case (state_ff)
         ST_RAW: begin
            md_req.a = hll_pkg::AM2;
            md_req.b = 64'd1 << 41;
            md_req.d = sum_ff;
         end
         ST_LOG: begin
            md_req.a = y_ff;
            md_req.b = y_ff;
            md_req.d = 64'd1 << 31;
         end
         ST_LN: begin
            md_req.a = tmp_ff;
            md_req.b = hll_pkg::LN2_Q32;
            md_req.d = 64'd1 << 32;
         end
         ST_LC: begin
            md_req.a = hll_pkg::REG_COUNT;
            md_req.b = tmp_ff;
            md_req.d = 64'd64;
         end
         ST_V: begin
            md_req.a = e_ff;
            md_req.b = 64'd1024;
            md_req.d = 64'd1000;
         end
         ST_V2: begin
            md_req.a = v_ff;
            md_req.b = v_ff;
            md_req.d = 64'd1 << 34;
         end
         ST_V3: begin
            md_req.a = v2_ff;
            md_req.b = v_ff;
            md_req.d = 64'd1 << 34;
         end
         ST_V4: begin
            md_req.a = v3_ff;
            md_req.b = v_ff;
            md_req.d = 64'd1 << 34;
         end
         ST_P1: begin
            md_req.a = v4_ff;
            md_req.b = 64'd59119;
            md_req.d = 64'd10000000000;
         end
         ST_P2: begin
            md_req.a = v2_ff;
            md_req.b = 64'd12940;
            md_req.d = 64'd100000;
         end
         ST_N1: begin
            md_req.a = v3_ff;
            md_req.b = 64'd14253;
            md_req.d = 64'd10000000;
         end
         ST_N2: begin
            md_req.a = v_ff;
            md_req.b = 64'd52921;
            md_req.d = 64'd10000;
         end
         ST_DELTA: begin
            md_req.a = e_ff;
            md_req.b = diff;
            md_req.d = 64'd100 << 34;
         end
         default: begin
            md_req.d = 64'd1;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      issued_in = issued_ff;
      sum_in = sum_ff;
      zero_in = zero_ff;
      q_in = q_ff;
      inf_in = inf_ff;
      method_in = method_ff;
      y_in = y_ff;
      frac_in = frac_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      tmp_in = tmp_ff;
      e_in = e_ff;
      v_in = v_ff;
      v2_in = v2_ff;
      v3_in = v3_ff;
      v4_in = v4_ff;
      pos_in = pos_ff;
      neg_in = neg_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (md_req.start) begin
         issued_in = 1'b1;
      end
      if (md_rsp.done) begin
         issued_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // accumulate, saturating both the sum and the zero count
               sum_in = sum_wide[64] ? '1 : sum_wide[63:0];
               if ((req_data.reg_value == 8'd0) && (zero_ff != hll_pkg::ZERO_MAX)) begin
                  zero_in = zero_ff + 15'd1;
               end
               if (req_data.last) begin
                  method_in = hll_pkg::METHOD_RAW;
                  inf_in = 1'b0;
                  state_in = ST_RAW;
               end
            end
         end
         ST_RAW: begin
            if (sum_ff == 64'd0) begin
               // empty sum: estimate is infinite
               inf_in = 1'b1;
               state_in = ST_ROUND;
            end else if (md_rsp.done) begin
               q_in = md_rsp.q;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((q_ff[127:64] == 64'd0) && (q_ff[63:0] <= hll_pkg::LC_LIMIT) &&
                (zero_ff != 15'd0)) begin
               method_in = hll_pkg::METHOD_LINEAR;
               k_in = msb;
               y_in = {49'd0, zero_ff} << (6'd31 - {1'b0, msb});
               frac_in = '0;
               cnt_in = '0;
               state_in = ST_LOG;
            end else if (hll_pkg::BC_ON && (q_ff[127:64] == 64'd0) &&
                         (q_ff[63:0] < hll_pkg::BC_LIMIT)) begin
               method_in = hll_pkg::METHOD_BIAS;
               e_in = q_ff[63:0];
               state_in = ST_V;
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_LOG: begin
            if (md_rsp.done) begin
               y_in = ybit ? (ysq >> 1) : ysq;
               frac_in = {frac_ff[28:0], ybit};
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd29) begin
                  state_in = ST_LZ;
               end
            end
         end
         ST_LZ: begin
            if (lz >= hll_pkg::LOG2_M) begin
               q_in = '0;
               state_in = ST_ROUND;
            end else begin
               tmp_in = hll_pkg::LOG2_M - lz;
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            if (md_rsp.done) begin
               tmp_in = res;
               state_in = ST_LC;
            end
         end
         ST_LC: begin
            if (md_rsp.done) begin
               q_in = {64'd0, res};
               state_in = ST_ROUND;
            end
         end
         ST_V: begin
            if (md_rsp.done) begin
               v_in = res;
               state_in = ST_V2;
            end
         end
         ST_V2: begin
            if (md_rsp.done) begin
               v2_in = res;
               state_in = ST_V3;
            end
         end
         ST_V3: begin
            if (md_rsp.done) begin
               v3_in = res;
               state_in = ST_V4;
            end
         end
         ST_V4: begin
            if (md_rsp.done) begin
               v4_in = res;
               state_in = ST_P1;
            end
         end
         ST_P1: begin
            if (md_rsp.done) begin
               pos_in = res + hll_pkg::BIAS_C0;
               state_in = ST_P2;
            end
         end
         ST_P2: begin
            if (md_rsp.done) begin
               pos_in = pos_ff + res;
               state_in = ST_N1;
            end
         end
         ST_N1: begin
            if (md_rsp.done) begin
               neg_in = res;
               state_in = ST_N2;
            end
         end
         ST_N2: begin
            if (md_rsp.done) begin
               neg_in = neg_ff + res;
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            if (md_rsp.done) begin
               // positive bias lowers the estimate, floored at zero
               if (pos_ge) begin
                  q_in = {64'd0, (res > e_ff) ? 64'd0 : (e_ff - res)};
               end else begin
                  q_in = {64'd0, e_ff + res};
               end
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_in.zero_count = zero_ff;
               rsp_in.method = method_ff;
               if (inf_ff || (rounded[127:87] != 41'd0)) begin
                  rsp_in.estimate = hll_pkg::EST_MAX;
                  rsp_in.saturated = 1'b1;
               end else begin
                  rsp_in.estimate = rounded[86:24];
                  rsp_in.saturated = 1'b0;
               end
               rsp_valid_in = 1'b1;
               sum_in = '0;
               zero_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issued_ff <= 1'b0;
         sum_ff <= '0;
         zero_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issued_ff <= issued_in;
         sum_ff <= sum_in;
         zero_ff <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff <= q_in;
      inf_ff <= inf_in;
      method_ff <= method_in;
      y_ff <= y_in;
      frac_ff <= frac_in;
      cnt_ff <= cnt_in;
      k_ff <= k_in;
      tmp_ff <= tmp_in;
      e_ff <= e_in;
      v_ff <= v_in;
      v2_ff <= v2_in;
      v3_ff <= v3_in;
      v4_ff <= v4_in;
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== src/hll_chk.sv =====
// Port checker for the estimator and its bind to the top level.
`default_nettype none
`include "hll_cardinality_estimator_assert.svh"
module hll_chk (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire hll_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire hll_pkg::rsp_type rsp_data
);

   `HLL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `HLL_ASSERT_NXT(a_busy_after_last, clock, reset, req_valid && !req_stall && req_data.last, req_stall)
   `HLL_ASSERT_IMP(a_sat_max, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.estimate == hll_pkg::EST_MAX)
   `HLL_ASSERT_IMP(a_method_code, clock, reset, rsp_valid, rsp_data.method != 2'd3)

endmodule

bind hll_cardinality_estimator hll_chk u_hll_chk (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the HyperLogLog cardinality estimator: stimulus, predictor and checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   localparam int unsigned SKETCH_M = 16384;
   localparam logic [14:0] ZERO_CAP = 15'd32767;
   localparam logic [62:0] EST_CAP = '1;
   localparam int DRAIN_CYCLES = 7000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   hll_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   hll_pkg::rsp_type rsp_data;

   hll_cardinality_estimator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Predictor state: the running inverse-power sum and the zero-register count.
   logic [63:0] inv_pow_sum;
   logic [14:0] zero_regs;

   hll_pkg::rsp_type pending_estimates[$];
   int          error_count = 0;
   int          requests_sent = 0;
   int          sketches_done = 0;
   int          method_hits[3] = '{0, 0, 0};
   int          saturated_hits = 0;
   bit          quiet = 1'b0;

   // floor(a*b/d), clamped to 64 bits
   function automatic logic [63:0] mul_div_floor(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] d);
      logic [127:0] q;
      q = ({64'b0, a} * {64'b0, b}) / {64'b0, d};
      return (q[127:64] != 64'd0) ? '1 : q[63:0];
   endfunction

   function automatic logic [63:0] log2_fixed(logic [63:0] n);
      int          k;
      logic [63:0] y;
      logic [63:0] frac;
      k = 0;
      frac = '0;
      while (k < 30 && (n >> (k + 1)) != 64'd0) k++;
      y = n << (31 - k);
      for (int i = 0; i < 30; i++) begin
         y = (y * y) >> 31;
         frac = frac << 1;
         if (y >= (64'd2 << 31)) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(k) << 30) | frac;
   endfunction

   function automatic logic [63:0] linear_count(logic [14:0] z);
      logic [63:0] lm;
      logic [63:0] lz;
      logic [63:0] ln_fixed;
      lm = log2_fixed(64'(SKETCH_M));
      lz = log2_fixed(64'(z));
      if (lz >= lm) return 64'd0;
      ln_fixed = mul_div_floor(lm - lz, 64'd2977044472, 64'd1 << 32);
      return mul_div_floor(64'(SKETCH_M), ln_fixed, 64'd64);
   endfunction

   // Subtract (or add, for a negative bias) the polynomial bias term.
   function automatic logic [63:0] bias_correct(logic [63:0] e);
      logic [63:0] v, v2, v3, v4, pos, neg, delta;
      v   = mul_div_floor(e, 64'd1024, 64'd1000);
      v2  = mul_div_floor(v, v, 64'd1 << 34);
      v3  = mul_div_floor(v2, v, 64'd1 << 34);
      v4  = mul_div_floor(v3, v, 64'd1 << 34);
      pos = mul_div_floor(v4, 64'd59119, 64'd10000000000)
          + mul_div_floor(v2, 64'd12940, 64'd100000)
          + mul_div_floor(64'd833216, 64'd1 << 34, 64'd10000);
      neg = mul_div_floor(v3, 64'd14253, 64'd10000000)
          + mul_div_floor(v, 64'd52921, 64'd10000);
      if (pos >= neg) begin
         delta = mul_div_floor(e, pos - neg, 64'd100 << 34);
         return (delta > e) ? 64'd0 : e - delta;
      end
      delta = mul_div_floor(e, neg - pos, 64'd100 << 34);
      return e + delta;
   endfunction

   function automatic logic [63:0] alpha_fixed();
      logic [63:0] m;
      m = 64'(SKETCH_M);
      if (m == 64'd16) return (64'd673 << 32) / 64'd1000;
      if (m == 64'd32) return (64'd697 << 32) / 64'd1000;
      if (m == 64'd64) return (64'd709 << 32) / 64'd1000;
      return ((64'd7213 * m) << 32) / (64'd10000 * m + 64'd10790);
   endfunction

   // Accumulate one register; on the last one form the estimate and clear.
   function automatic bit estimate_sketch(hll_pkg::req_type item,
                                          output hll_pkg::rsp_type res);
      logic [63:0]         term;
      logic [63:0]         am2;
      logic [127:0]        q;
      logic [127:0]        rounded;
      hll_pkg::method_type how;
      res = '0;
      term = (item.reg_value <= 8'd49) ? (64'd1 << (49 - item.reg_value)) : 64'd0;
      inv_pow_sum = (inv_pow_sum > ~term) ? '1 : inv_pow_sum + term;
      if (item.reg_value == 8'd0 && zero_regs != ZERO_CAP) zero_regs++;
      if (!item.last) return 1'b0;
      res.zero_count = zero_regs;
      how = hll_pkg::METHOD_RAW;
      if (inv_pow_sum == 64'd0) begin
         res.estimate = EST_CAP;
         res.saturated = 1'b1;
      end else begin
         am2 = alpha_fixed() * 64'(SKETCH_M) * 64'(SKETCH_M);
         q = ({64'b0, am2} << 41) / {64'b0, inv_pow_sum};
         if (q[127:64] == 64'd0 && q[63:0] <= ((64'd5 * SKETCH_M) << 23)
             && zero_regs != 15'd0) begin
            how = hll_pkg::METHOD_LINEAR;
            q = {64'b0, linear_count(zero_regs)};
         end else if (SKETCH_M == 16384 && q[127:64] == 64'd0
                      && q[63:0] < (64'd72000 << 24)) begin
            how = hll_pkg::METHOD_BIAS;
            q = {64'b0, bias_correct(q[63:0])};
         end
         rounded = (q + (128'd1 << 23)) >> 24;
         if (rounded > {65'b0, EST_CAP}) begin
            res.estimate = EST_CAP;
            res.saturated = 1'b1;
         end else begin
            res.estimate = rounded[62:0];
         end
      end
      res.method = how;
      inv_pow_sum = '0;
      zero_regs = '0;
      return 1'b1;
   endfunction

   // Present one request, optionally after an idle burst; predict on acceptance.
   task automatic send_register(hll_pkg::req_type item, int idle_odds, bit typed = 1'b0,
                                hll_pkg::rsp_type typed_rsp = '0);
      hll_pkg::rsp_type res;
      if (!quiet && $urandom_range(idle_odds - 1) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (estimate_sketch(item, res)) begin
         // typed rows carry an expectation worked out by hand
         pending_estimates.push_back(typed ? typed_rsp : res);
         sketches_done++;
      end
      @(negedge clock);
   endtask

   // Geometric rank from a base upward, or zero with probability zero_pct percent.
   function automatic logic [7:0] draw_rank(int zero_pct, int base);
      int r;
      if ($urandom_range(99) < zero_pct) return 8'd0;
      r = base;
      while ($urandom_range(1) == 1 && r < 255) r++;
      return 8'(r);
   endfunction

   task automatic send_short_sketch();
      hll_pkg::req_type item;
      int               len;
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) < 3) item.reg_value = 8'($urandom_range(0, 255));
         else item.reg_value = draw_rank($urandom_range(0, 30), $urandom_range(0, 20));
         item.last = (i == len - 1);
         send_register(item, 6);
      end
   endtask

   // Output side: random stall bursts, none once the run goes quiet.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         rsp_stall = 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         if (!quiet) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
      end
   end

   // Compare each accepted result against the oldest expectation.
   always @(posedge clock) begin
      hll_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_estimates.size() == 0) begin
            $error("unexpected result: estimate %0d", rsp_data.estimate);
            error_count++;
         end else begin
            exp_rsp = pending_estimates.pop_front();
            if (rsp_data.estimate !== exp_rsp.estimate) begin
               $error("estimate: expected %0d, actual %0d", exp_rsp.estimate,
                      rsp_data.estimate);
               error_count++;
            end
            if (rsp_data.zero_count !== exp_rsp.zero_count) begin
               $error("zero_count: expected %0d, actual %0d", exp_rsp.zero_count,
                      rsp_data.zero_count);
               error_count++;
            end
            if (rsp_data.method !== exp_rsp.method) begin
               $error("method: expected %0d, actual %0d", exp_rsp.method,
                      rsp_data.method);
               error_count++;
            end
            if (rsp_data.saturated !== exp_rsp.saturated) begin
               $error("saturated: expected %0d, actual %0d", exp_rsp.saturated,
                      rsp_data.saturated);
               error_count++;
            end
            if (exp_rsp.method <= 2'd2) method_hits[exp_rsp.method]++;
            if (exp_rsp.saturated) saturated_hits++;
         end
      end
   end

   typedef struct {
      hll_pkg::req_type req;
      bit               typed;
      hll_pkg::rsp_type rsp;
   } stim_row;

   initial begin
      stim_row          rows[14];
      hll_pkg::rsp_type sat_rsp;
      sat_rsp = '{estimate: EST_CAP, zero_count: 15'd0, method: hll_pkg::METHOD_RAW,
                  saturated: 1'b1};
      // Directed table: the empty-sum and huge-estimate rows are typed in,
      // everything else goes through the predictor.
      rows[0]  = '{'{8'd50, 1'b1}, 1'b1, sat_rsp};   // rank past the sum: sum stays zero
      rows[1]  = '{'{8'd255, 1'b1}, 1'b1, sat_rsp};  // widest rank, same
      rows[2]  = '{'{8'd49, 1'b1}, 1'b1, sat_rsp};   // smallest term: estimate clamps
      rows[3]  = '{'{8'd0, 1'b1}, 1'b0, '0};         // single zero register
      rows[4]  = '{'{8'd0, 1'b0}, 1'b0, '0};
      rows[5]  = '{'{8'd255, 1'b0}, 1'b0, '0};
      rows[6]  = '{'{8'hAA, 1'b0}, 1'b0, '0};
      rows[7]  = '{'{8'h55, 1'b0}, 1'b0, '0};
      rows[8]  = '{'{8'd1, 1'b0}, 1'b0, '0};
      rows[9]  = '{'{8'd48, 1'b1}, 1'b0, '0};
      rows[10] = '{'{8'd2, 1'b0}, 1'b0, '0};
      rows[11] = '{'{8'd128, 1'b0}, 1'b0, '0};
      rows[12] = '{'{8'd0, 1'b0}, 1'b0, '0};
      rows[13] = '{'{8'd7, 1'b1}, 1'b0, '0};

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      inv_pow_sum = '0;
      zero_regs = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_register(rows[i].req, 4, rows[i].typed, rows[i].rsp);

      // Hold off the input until every outstanding estimate has drained.
      req_valid = 1'b0;
      wait (pending_estimates.size() == 0);
      @(negedge clock);

      while (requests_sent < 450) send_short_sketch();

      quiet = 1'b1;
      repeat (5) send_short_sketch();
      req_valid = 1'b0;

      wait (pending_estimates.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests in %0d sketches; raw %0d, linear %0d, bias %0d,",
               requests_sent, sketches_done, method_hits[0], method_hits[1],
               method_hits[2]);
      $display("with %0d clamped estimates and %0d errors.", saturated_hits, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #400_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

// ===== hll_cardinality_estimator.f =====
+incdir+src
src/hll_pkg.sv
src/hll_muldiv.sv
src/hll_cardinality_estimator.sv
src/hll_chk.sv
verif/tb_top.sv
